/* hw/rtl/dsl_byte_tokenizer_top_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the byte tokenizer checker
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DSL_BYTE_TOKENIZER_TOP_ASSERT_SVH
`define DSL_BYTE_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication
`define DBT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dbt check failed");

// next-cycle implication
`define DBT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dbt check failed");

`endif

/* hw/rtl/dbt_pkg.sv */
// ---------------------------------------------------------------------------
// dbt_pkg
// Shared types and constants of the byte tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none

package dbt_pkg;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 4;
  localparam int TOK_OFF_W  = 32;
  localparam int TOK_LEN_W  = 8;
  localparam int PREFIX_N   = 5;

  typedef enum logic [3:0] {
    KIND_VAR    = 4'd0,
    KIND_DEF    = 4'd1,
    KIND_ARROW  = 4'd2,
    KIND_NAME   = 4'd3,
    KIND_LPAREN = 4'd4,
    KIND_RPAREN = 4'd5,
    KIND_COMMA  = 4'd6,
    KIND_KW0    = 4'd7,
    KIND_KW1    = 4'd8,
    KIND_KW2    = 4'd9,
    KIND_KW3    = 4'd10,
    KIND_END    = 4'd11
  } tok_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NAME    = 3'd1,
    MODE_VAR     = 3'd2,
    MODE_EQ      = 3'd3,
    MODE_SLASH   = 3'd4,
    MODE_COMMENT = 3'd5
  } lex_mode_t;

  typedef struct packed {
    tok_kind_t              kind;
    logic [TOK_OFF_W-1:0]   offset;
    logic [TOK_LEN_W-1:0]   len;
    logic                   sat;
    logic                   last;
  } tok_t;

  // tokens produced by one source byte, packed from tok0 up
  typedef struct packed {
    tok_t       tok0;
    tok_t       tok1;
    logic [1:0] count;
  } tok_pair_t;

  typedef logic [PREFIX_N-1:0][7:0] prefix_t;

  localparam logic [7:0] CH_QUEST  = 8'h3f;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // keyword spellings, first byte in the low lane, zero padded
  localparam prefix_t KW_TEXT [4] = '{
    {8'h00, 8'h64, 8'h6c, 8'h6f, 8'h6d},
    {8'h00, 8'h68, 8'h74, 8'h69, 8'h77},
    {8'h00, 8'h00, 8'h74, 8'h65, 8'h73},
    {8'h65, 8'h70, 8'h61, 8'h68, 8'h73}
  };
  localparam int KW_LEN [4] = '{4, 4, 3, 5};
  localparam tok_kind_t KW_KIND [4] = '{KIND_KW0, KIND_KW1, KIND_KW2, KIND_KW3};

  function automatic logic is_name_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/dbt_lex_core.sv */
// ---------------------------------------------------------------------------
// dbt_lex_core
// Lexer state and per-byte token logic; up to two tokens per byte.
// ---------------------------------------------------------------------------
`default_nettype none

module dbt_lex_core #(
  parameter int OFFSET_BITS     = 32,
  parameter int MAX_NAME_LENGTH = 255
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          char_byte,
  input  logic                end_of_source,
  output dbt_pkg::tok_pair_t  toks
);
  import dbt_pkg::*;

  localparam int RL_W = $clog2(MAX_NAME_LENGTH + 1);
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  lex_mode_t              mode_r,   mode_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [OFFSET_BITS-1:0] start_r,  start_nxt;
  logic [RL_W-1:0]        run_r,    run_nxt;
  logic                   ovf_r,    ovf_nxt;
  prefix_t                prefix_r, prefix_nxt;

  tok_t tok_a, tok_b, pend_tok;
  logic a_v, b_v, pend_v;
  logic is_end, name_c, handled, flush;

  function automatic tok_t make_tok(input tok_kind_t kind,
                                    input logic [OFFSET_BITS-1:0] off,
                                    input logic [TOK_LEN_W-1:0] len,
                                    input logic sat);
    tok_t t;
    logic [63:0] wide;
    wide     = 64'(off);
    t.kind   = kind;
    t.offset = wide[TOK_OFF_W-1:0];
    t.len    = len;
    t.sat    = sat | (off == OFF_MAX);
    t.last   = 1'b0;
    return t;
  endfunction

  // pending name or variable, with keyword lookup and length clipping
  function automatic tok_t name_tok();
    tok_kind_t kind;
    logic      clip;
    kind = (mode_r == MODE_NAME) ? KIND_NAME : KIND_VAR;
    if (mode_r == MODE_NAME) begin
      for (int k = 0; k < 4; k++) begin
        if (!ovf_r && run_r == RL_W'(KW_LEN[k]) && prefix_r == KW_TEXT[k]) begin
          kind = KW_KIND[k];
        end
      end
    end
    clip = (32'(run_r) > 32'd255);
    return make_tok(kind, start_r, clip ? 8'hff : TOK_LEN_W'(run_r), ovf_r | clip);
  endfunction

  always_comb begin
    is_end = end_of_source || (char_byte == CH_NUL);
    name_c = is_name_char(char_byte);

    pend_v   = 1'b0;
    pend_tok = make_tok(KIND_NAME, start_r, 8'd1, 1'b0);
    unique case (mode_r)
      MODE_NAME, MODE_VAR: begin
        pend_v   = 1'b1;
        pend_tok = name_tok();
      end
      MODE_EQ, MODE_SLASH: begin
        pend_v = 1'b1;
      end
      default: pend_v = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    offset_nxt = offset_r;
    start_nxt  = start_r;
    run_nxt    = run_r;
    ovf_nxt    = ovf_r;
    prefix_nxt = prefix_r;
    a_v        = 1'b0;
    b_v        = 1'b0;
    tok_a      = pend_tok;
    tok_b      = make_tok(KIND_END, offset_r, 8'd0, 1'b0);
    handled    = 1'b0;
    flush      = 1'b0;

    if (is_end) begin
      a_v        = pend_v;
      b_v        = 1'b1;
      mode_nxt   = MODE_IDLE;
      offset_nxt = '0;
      start_nxt  = '0;
      run_nxt    = '0;
      ovf_nxt    = 1'b0;
      prefix_nxt = '0;
    end else begin
      unique case (mode_r)
        MODE_NAME, MODE_VAR: begin
          if (name_c) begin
            handled = 1'b1;
            if (run_r < RL_W'(PREFIX_N)) begin
              prefix_nxt[run_r[2:0]] = char_byte;
            end
            if (run_r < RL_W'(MAX_NAME_LENGTH)) begin
              run_nxt = run_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            flush = 1'b1;
          end
        end
        MODE_EQ: begin
          if (char_byte == CH_GT) begin
            handled  = 1'b1;
            a_v      = 1'b1;
            tok_a    = make_tok(KIND_ARROW, start_r, 8'd2, 1'b0);
            mode_nxt = MODE_IDLE;
          end else begin
            flush = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (char_byte == CH_SLASH) begin
            handled  = 1'b1;
            mode_nxt = MODE_COMMENT;
          end else begin
            flush = 1'b1;
          end
        end
        MODE_COMMENT: begin
          handled = 1'b1;
          if (char_byte == CH_NL) begin
            mode_nxt = MODE_IDLE;
          end
        end
        default: mode_nxt = MODE_IDLE;
      endcase

      if (flush) begin
        a_v      = 1'b1;
        mode_nxt = MODE_IDLE;
      end

      if (!handled) begin
        priority if (char_byte == CH_QUEST || char_byte == CH_EQ ||
                     char_byte == CH_SLASH) begin
          mode_nxt   = (char_byte == CH_QUEST) ? MODE_VAR :
                       (char_byte == CH_EQ)    ? MODE_EQ  : MODE_SLASH;
          start_nxt  = offset_r;
          run_nxt    = '0;
          ovf_nxt    = 1'b0;
          prefix_nxt = '0;
        end else if (char_byte == CH_COLON) begin
          b_v   = 1'b1;
          tok_b = make_tok(KIND_DEF, offset_r, 8'd1, 1'b0);
        end else if (char_byte == CH_LPAREN) begin
          b_v   = 1'b1;
          tok_b = make_tok(KIND_LPAREN, offset_r, 8'd1, 1'b0);
        end else if (char_byte == CH_RPAREN) begin
          b_v   = 1'b1;
          tok_b = make_tok(KIND_RPAREN, offset_r, 8'd1, 1'b0);
        end else if (char_byte == CH_COMMA) begin
          b_v   = 1'b1;
          tok_b = make_tok(KIND_COMMA, offset_r, 8'd1, 1'b0);
        end else if (name_c) begin
          mode_nxt      = MODE_NAME;
          start_nxt     = offset_r;
          run_nxt       = RL_W'(1);
          ovf_nxt       = 1'b0;
          prefix_nxt    = '0;
          prefix_nxt[0] = char_byte;
        end else begin
          // skipped byte
          mode_nxt = mode_nxt;
        end
      end

      if (offset_r != OFF_MAX) begin
        offset_nxt = offset_r + 1'b1;
      end
    end
  end

  // compact the two slots and mark the last token of the byte
  always_comb begin
    toks.tok0 = a_v ? tok_a : tok_b;
    toks.tok1 = tok_b;
    toks.tok1.last = 1'b1;
    toks.tok0.last = !(a_v && b_v);
    toks.count = 2'(a_v) + 2'(b_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      offset_r <= '0;
      start_r  <= '0;
      run_r    <= '0;
      ovf_r    <= 1'b0;
      prefix_r <= '0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      offset_r <= offset_nxt;
      start_r  <= start_nxt;
      run_r    <= run_nxt;
      ovf_r    <= ovf_nxt;
      prefix_r <= prefix_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dbt_tok_fifo.sv */
// ---------------------------------------------------------------------------
// dbt_tok_fifo
// Four-entry token queue; takes up to two tokens, gives one per ready cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module dbt_tok_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dbt_pkg::tok_pair_t toks,
  output logic               room_two,
  output logic               out_valid,
  input  logic               out_ready,
  output dbt_pkg::tok_t      out_tok
);
  import dbt_pkg::*;

  tok_t       mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r,    cnt_nxt;
  logic [1:0] n_push;
  logic       pop;

  assign room_two  = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_tok   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign n_push    = push ? toks.count : 2'd0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push;
    rd_ptr_nxt = rd_ptr_r + 2'(pop);
    cnt_nxt    = cnt_r + 3'(n_push) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= toks.tok0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= toks.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dsl_byte_tokenizer_top.sv */
// ---------------------------------------------------------------------------
// dsl_byte_tokenizer_top
// Source byte stream in, token stream (kind, offset, length) out.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream: one source byte per request in in_tdata; in_tlast marks end
//   of source (the byte is then ignored). A zero byte also ends the source.
//   Output stream: one token per request; kind in out_tuser, offset, length
//   and saturation flag in out_tdata; out_tlast is set on the last token
//   caused by a given byte. A byte yields zero, one or two tokens.
//   Path: an accepted byte waits in the input register, and its tokens pass
//   through the token queue to the output.
//   Throughput: one byte per cycle. Bytes that give two tokens drain at one
//   token per cycle, so a long run of them is held to the output rate.
//   The lexer steps only when the four-entry token queue has room for two
//   tokens; when the receiver stalls, the queue fills and in_tready drops.
//   Reset: synchronous, active low; lexer idle, offset zero, queue empty.
//   An end of source also returns the lexer to its reset state.
// ---------------------------------------------------------------------------
`default_nettype none

module dsl_byte_tokenizer_top #(
  parameter int OFFSET_BITS     = 32,
  parameter int MAX_NAME_LENGTH = 255
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dbt_pkg::IN_DATA_W-1:0]      in_tdata,   // [7:0] char_byte
  input  logic                               in_tlast,   // end_of_source
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dbt_pkg::OUT_DATA_W-1:0]     out_tdata,  // [31:0] token_offset,
                                                         // [39:32] text_length,
                                                         // [40] length_saturated
  output logic [dbt_pkg::OUT_USER_W-1:0]     out_tuser,  // [3:0] token_kind
  output logic                               out_tlast   // last_of_run
);
  import dbt_pkg::*;

  logic       st_valid_r;
  logic [7:0] st_byte_r;
  logic       st_end_r;
  logic       room_two;
  logic       adv;
  tok_pair_t  toks;
  tok_t       out_tok;

  assign adv       = st_valid_r && room_two;
  assign in_tready = !st_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      st_valid_r <= 1'b1;
    end else if (adv) begin
      st_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      st_byte_r <= in_tdata[7:0];
      st_end_r  <= in_tlast;
    end
  end

  dbt_lex_core #(
    .OFFSET_BITS     (OFFSET_BITS),
    .MAX_NAME_LENGTH (MAX_NAME_LENGTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (adv),
    .char_byte     (st_byte_r),
    .end_of_source (st_end_r),
    .toks          (toks)
  );

  dbt_tok_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .toks      (toks),
    .room_two  (room_two),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (out_tok)
  );

  assign out_tdata = {7'd0, out_tok.sat, out_tok.len, out_tok.offset};
  assign out_tuser = out_tok.kind;
  assign out_tlast = out_tok.last;

endmodule

`default_nettype wire

/* hw/rtl/dbt_checker.sv */
// ---------------------------------------------------------------------------
// dbt_checker
// Port-level checks on the tokenizer's result stream.
// ---------------------------------------------------------------------------
`default_nettype none

`include "dsl_byte_tokenizer_top_assert.svh"

module dbt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [dbt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [dbt_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                           out_tlast
);
  import dbt_pkg::*;

  logic [OUT_DATA_W+OUT_USER_W:0] out_bus;

  assign out_bus = {out_tdata, out_tuser, out_tlast};

  // stalled token holds
  `DBT_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_bus))

  // end token is empty and closes its byte's run
  `DBT_ASSERT_IMP(a_end_tok, out_tvalid && out_tuser == KIND_END, out_tdata[39:32] == 8'd0 && out_tlast)

  // arrow always covers two bytes
  `DBT_ASSERT_IMP(a_arrow_len, out_tvalid && out_tuser == KIND_ARROW, out_tdata[39:32] == 8'd2)

  // padding bits stay clear
  `DBT_ASSERT_IMP(a_pad_zero, out_tvalid, out_tdata[47:41] == 7'd0)

endmodule

bind dsl_byte_tokenizer_top dbt_checker u_dbt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

/* bench/tb_dsl_byte_tokenizer_top.sv */
// ---------------------------------------------------------------------------
// tb_dsl_byte_tokenizer_top
// Feeds source bytes into the tokenizer and checks every token it returns
// against a cycle-free lexer model kept in the bench. A short table of
// hand-picked bytes runs first, then random well-formed source with noise.
// Both streams idle at random, apart from one stretch where neither does.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_dsl_byte_tokenizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dbt_pkg::*;

  // narrower offset than the block's default
  localparam int OFF_BITS     = 16;
  localparam int NAME_CAP     = 255;
  localparam int RANDOM_BYTES = 620;
  localparam int QUIET_FROM   = 300;
  localparam int QUIET_TO     = 500;
  localparam logic [OFF_BITS-1:0] POS_MAX = '1;

  // keyword spellings, first letter in the low byte
  localparam logic [39:0] KW_SPELL [4] = '{
    40'h00646c6f6d, 40'h0068746977, 40'h0000746573, 40'h6570616873
  };
  localparam int        KW_SIZE  [4] = '{4, 4, 3, 5};
  localparam tok_kind_t KW_KINDS [4] = '{KIND_KW0, KIND_KW1, KIND_KW2, KIND_KW3};

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       typed;  // want holds the one token this byte must give
    tok_t       want;
  } src_item_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        eos;
    logic        typed;
    tok_kind_t   kind;
    logic [15:0] pos;
    logic [7:0]  len;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [26] = '{
    '{CH_COLON,  1'b0, 1'b1, KIND_DEF,    16'd0, 8'd1},
    '{CH_LPAREN, 1'b0, 1'b1, KIND_LPAREN, 16'd1, 8'd1},
    '{CH_RPAREN, 1'b0, 1'b1, KIND_RPAREN, 16'd2, 8'd1},
    '{CH_COMMA,  1'b0, 1'b1, KIND_COMMA,  16'd3, 8'd1},
    '{8'hff,     1'b1, 1'b1, KIND_END,    16'd4, 8'd0},
    // first keyword, closed by a space
    '{8'h6d,     1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    '{8'h6f,     1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    '{8'h6c,     1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    '{8'h64,     1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    '{8'h20,     1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    // "shape(" gives two tokens on one byte
    '{8'h73,     1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    '{8'h68,     1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    '{8'h61,     1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    '{8'h70,     1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    '{8'h65,     1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    '{CH_LPAREN, 1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    // empty variable
    '{CH_QUEST,  1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    '{CH_RPAREN, 1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    '{CH_EQ,     1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    '{CH_GT,     1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    // comment holding a non-ASCII byte
    '{CH_SLASH,  1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    '{CH_SLASH,  1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    '{8'h80,     1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    '{CH_NL,     1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    // lone '=' flushed by a zero byte
    '{CH_EQ,     1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0},
    '{CH_NUL,    1'b0, 1'b0, KIND_NAME,   16'd0, 8'd0}
  };

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  // lexer model state
  lex_mode_t             lx_mode;
  logic [OFF_BITS-1:0]   lx_pos;
  logic [OFF_BITS-1:0]   lx_start;
  int unsigned           lx_len;
  logic                  lx_ovf;
  logic [4:0][7:0]       lx_prefix;
  tok_t                  step_tok [2];
  int                    step_n;

  src_item_t   byte_q [$];   // source bytes not yet sent
  tok_t        token_q [$];  // tokens owed by the block, oldest first
  src_item_t   held;
  int unsigned cyc  = 0;
  int          errs = 0;

  dsl_byte_tokenizer_top #(
    .OFFSET_BITS     (OFF_BITS),
    .MAX_NAME_LENGTH (NAME_CAP)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------- lexer model ----------------

  function automatic bit is_word_byte(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h5f;
  endfunction

  task automatic lex_clear();
    lx_mode   = MODE_IDLE;
    lx_pos    = '0;
    lx_start  = '0;
    lx_len    = 0;
    lx_ovf    = 1'b0;
    lx_prefix = '0;
  endtask

  task automatic emit_tok(tok_kind_t k, logic [OFF_BITS-1:0] at, int unsigned len,
                          logic flag);
    tok_t t;
    if (step_n < 2) begin
      if (at == POS_MAX) flag = 1'b1;
      if (len > 255) begin
        len  = 255;
        flag = 1'b1;
      end
      t.kind   = k;
      t.offset = 32'(at);
      t.len    = len[7:0];
      t.sat    = flag;
      t.last   = 1'b0;
      step_tok[step_n] = t;
      step_n++;
    end
  endtask

  task automatic open_word(lex_mode_t m);
    lx_mode   = m;
    lx_start  = lx_pos;
    lx_len    = 0;
    lx_ovf    = 1'b0;
    lx_prefix = '0;
  endtask

  task automatic grow_word(logic [7:0] c);
    if (lx_len < 5) lx_prefix[3'(lx_len)] = c;
    if (lx_len < NAME_CAP) lx_len++;
    else lx_ovf = 1'b1;
  endtask

  task automatic close_pending();
    tok_kind_t k;
    case (lx_mode)
      MODE_NAME, MODE_VAR: begin
        k = KIND_VAR;
        if (lx_mode == MODE_NAME) begin
          k = KIND_NAME;
          for (int i = 0; i < 4; i++)
            if (!lx_ovf && lx_len == KW_SIZE[i] && lx_prefix == KW_SPELL[i])
              k = KW_KINDS[i];
        end
        emit_tok(k, lx_start, lx_len, lx_ovf);
      end
      MODE_EQ, MODE_SLASH: emit_tok(KIND_NAME, lx_start, 1, 1'b0);
      default: ;
    endcase
    lx_mode = MODE_IDLE;
  endtask

  // one accepted source byte: advance the model and queue the tokens owed
  task automatic lex_byte(src_item_t s);
    bit took;
    took   = 1'b0;
    step_n = 0;
    if (s.eos || s.ch == CH_NUL) begin
      close_pending();
      emit_tok(KIND_END, lx_pos, 0, 1'b0);
      lex_clear();
    end else begin
      case (lx_mode)
        MODE_NAME, MODE_VAR: begin
          if (is_word_byte(s.ch)) begin
            grow_word(s.ch);
            took = 1'b1;
          end else close_pending();
        end
        MODE_EQ: begin
          if (s.ch == CH_GT) begin
            emit_tok(KIND_ARROW, lx_start, 2, 1'b0);
            lx_mode = MODE_IDLE;
            took    = 1'b1;
          end else close_pending();
        end
        MODE_SLASH: begin
          if (s.ch == CH_SLASH) begin
            lx_mode = MODE_COMMENT;
            took    = 1'b1;
          end else close_pending();
        end
        MODE_COMMENT: begin
          if (s.ch == CH_NL) lx_mode = MODE_IDLE;
          took = 1'b1;
        end
        default: lx_mode = MODE_IDLE;
      endcase
      if (!took) begin
        case (s.ch)
          CH_QUEST:  open_word(MODE_VAR);
          CH_EQ:     open_word(MODE_EQ);
          CH_SLASH:  open_word(MODE_SLASH);
          CH_COLON:  emit_tok(KIND_DEF, lx_pos, 1, 1'b0);
          CH_LPAREN: emit_tok(KIND_LPAREN, lx_pos, 1, 1'b0);
          CH_RPAREN: emit_tok(KIND_RPAREN, lx_pos, 1, 1'b0);
          CH_COMMA:  emit_tok(KIND_COMMA, lx_pos, 1, 1'b0);
          default: begin
            if (is_word_byte(s.ch)) begin
              open_word(MODE_NAME);
              grow_word(s.ch);
            end
          end
        endcase
      end
      if (lx_pos != POS_MAX) lx_pos++;
    end
    if (step_n > 0) step_tok[step_n-1].last = 1'b1;
    if (s.typed) token_q.push_back(s.want);
    else
      for (int i = 0; i < step_n; i++) token_q.push_back(step_tok[i]);
  endtask

  // ---------------- source generation ----------------

  task automatic put_byte(logic [7:0] c);
    src_item_t s;
    s    = '0;
    s.ch = c;
    byte_q.push_back(s);
  endtask

  // end of source, either flagged by tlast with a junk byte or as a zero byte
  task automatic put_end();
    src_item_t s;
    s     = '0;
    s.eos = 1'($urandom_range(1));
    s.ch  = s.eos ? 8'($urandom_range(255)) : CH_NUL;
    byte_q.push_back(s);
  endtask

  function automatic logic [7:0] word_byte();
    int r;
    r = $urandom_range(62);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    if (r < 62) return 8'(8'h30 + r - 52);
    return CH_UNDER;
  endfunction

  task automatic put_word(int n);
    for (int i = 0; i < n; i++) put_byte(word_byte());
  endtask

  // keyword, sometimes one letter short or one letter long
  task automatic put_keyword();
    int k;
    int r;
    int n;
    k = $urandom_range(3);
    r = $urandom_range(99);
    n = KW_SIZE[k];
    if (r < 15) n--;
    for (int i = 0; i < n; i++) put_byte(KW_SPELL[k][8*i +: 8]);
    if (r >= 85) put_byte(word_byte());
  endtask

  task automatic put_piece();
    int          pick;
    logic [7:0]  c;
    logic [7:0]  sep [3];
    sep  = '{8'h20, 8'h09, CH_NL};
    pick = $urandom_range(99);
    if (pick < 20) put_keyword();
    else if (pick < 38) put_word($urandom_range(1, 8));
    else if (pick < 40) put_word($urandom_range(250, 300));
    else if (pick < 50) begin
      put_byte(CH_QUEST);
      if ($urandom_range(3) == 0) put_keyword();
      else put_word($urandom_range(0, 6));
    end else if (pick < 57) begin
      put_byte(CH_EQ);
      put_byte(CH_GT);
    end else if (pick < 63) begin
      put_byte(CH_SLASH);
      put_byte(CH_SLASH);
      repeat ($urandom_range(0, 10)) begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_NL);
        put_byte(c);
      end
      if ($urandom_range(4) != 0) put_byte(CH_NL);
    end else if (pick < 75) begin
      case ($urandom_range(3))
        0: put_byte(CH_COLON);
        1: put_byte(CH_LPAREN);
        2: put_byte(CH_RPAREN);
        default: put_byte(CH_COMMA);
      endcase
    end else if (pick < 80) put_byte($urandom_range(1) ? CH_EQ : CH_SLASH);
    else if (pick < 89) put_byte(8'($urandom_range(1, 255)));
    else if (pick < 96) repeat ($urandom_range(1, 3)) put_byte(sep[$urandom_range(2)]);
    else put_end();
    if ($urandom_range(1)) put_byte(8'h20);
  endtask

  task automatic build_source();
    src_item_t s;
    int        base;
    foreach (DIR_TAB[i]) begin
      s             = '0;
      s.ch          = DIR_TAB[i].ch;
      s.eos         = DIR_TAB[i].eos;
      s.typed       = DIR_TAB[i].typed;
      s.want.kind   = DIR_TAB[i].kind;
      s.want.offset = 32'(DIR_TAB[i].pos);
      s.want.len    = DIR_TAB[i].len;
      s.want.sat    = 1'b0;
      s.want.last   = 1'b1;
      byte_q.push_back(s);
    end

    base = byte_q.size();
    while (byte_q.size() < base + RANDOM_BYTES) put_piece();
    // close the last source so every pending token comes out
    put_end();
  endtask

  // ---------------- checking ----------------

  task automatic note_fault(string msg);
    errs++;
    if (errs <= 10) $display("%s", msg);
  endtask

  task automatic check_token();
    tok_t want;
    if (token_q.size() == 0) begin
      note_fault($sformatf("unexpected token: kind %0d data %h last %0b",
                           out_tuser, out_tdata, out_tlast));
    end else begin
      want = token_q.pop_front();
      if (out_tuser !== 4'(want.kind) ||
          out_tdata !== {7'd0, want.sat, want.len, want.offset} ||
          out_tlast !== want.last)
        note_fault($sformatf({"token mismatch: expected kind %0d off %0d len %0d sat %0b ",
                              "last %0b, got kind %0d off %0d len %0d sat %0b last %0b ",
                              "(pad %h)"},
                             want.kind, want.offset, want.len, want.sat, want.last,
                             out_tuser, out_tdata[31:0], out_tdata[39:32], out_tdata[40],
                             out_tlast, out_tdata[47:41]));
    end
  endtask

  always @(posedge clk) begin : drive
    bit calm;
    cyc  <= cyc + 1;
    calm = (cyc >= QUIET_FROM && cyc < QUIET_TO);
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      // model first, so a token never outruns the request that caused it
      if (in_tvalid && in_tready) lex_byte(held);
      if (out_tvalid && out_tready) check_token();
      if (!in_tvalid || in_tready) begin
        if (byte_q.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
          held = byte_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= held.ch;
          in_tlast  <= held.eos;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= calm || ($urandom_range(99) >= 23);
    end
  end

  initial begin
    lex_clear();
    build_source();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (byte_q.size() != 0 || in_tvalid) @(negedge clk);
    while (token_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errs == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #100_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+hw/rtl
hw/rtl/dbt_pkg.sv
hw/rtl/dbt_lex_core.sv
hw/rtl/dbt_tok_fifo.sv
hw/rtl/dsl_byte_tokenizer_top.sv
hw/rtl/dbt_checker.sv
bench/tb_dsl_byte_tokenizer_top.sv
